// File: rtl/core/loco_pkg.sv
// Package for the locomotive slot command handler: opcodes, result kinds,
// slot layout constants and the front-to-back command record. No dependencies.
`timescale 1ns / 1ps
package loco_pkg;
    localparam int SLOT_COUNT_DEF = 32;
    localparam int SLOT_BYTES     = 13;

    localparam logic [7:0] OPC_PWR_ON  = 8'h83;
    localparam logic [7:0] OPC_PWR_OFF = 8'h82;
    localparam logic [7:0] OPC_ESTOP   = 8'h85;
    localparam logic [7:0] OPC_LOCO    = 8'hBF;
    localparam logic [7:0] OPC_MOVE    = 8'hBA;
    localparam logic [7:0] OPC_SPD     = 8'hA0;
    localparam logic [7:0] OPC_DIRF    = 8'hA1;
    localparam logic [7:0] OPC_SND     = 8'hA2;
    localparam logic [7:0] OPC_SW      = 8'hB0;

    // long acknowledge reply: opcode and echoed request code
    localparam logic [7:0] OPC_LACK  = 8'hB4;
    localparam logic [7:0] LACK_ECHO = 8'hE5;

    localparam logic [2:0] KIND_PWR_ON  = 3'd0;
    localparam logic [2:0] KIND_PWR_OFF = 3'd1;
    localparam logic [2:0] KIND_ESTOP   = 3'd2;
    localparam logic [2:0] KIND_THR     = 3'd3;
    localparam logic [2:0] KIND_FUNC    = 3'd4;
    localparam logic [2:0] KIND_ACC     = 3'd5;
    localparam logic [2:0] KIND_TX      = 3'd6;

    localparam logic [7:0] SLOT_OPC  = 8'hE7;
    localparam logic [7:0] SLOT_SIZE = 8'h0E;
    localparam logic [7:0] MODE_128  = 8'h03;
    localparam logic [7:0] STAT_IDLE = 8'h10;
    localparam logic [7:0] STAT_USE  = 8'h30;
    localparam logic [7:0] DIRF_F0   = 8'h10;

    // Classified command codes
    typedef enum logic [3:0] {
        OP_SIMPLE = 4'd0, // one result, no table access (power, stop, switch)
        OP_LOCO   = 4'd1,
        OP_MOVE   = 4'd2,
        OP_SPD    = 4'd3,
        OP_DIRF   = 4'd4,
        OP_SND    = 4'd5,
        OP_NACK   = 4'd6  // long acknowledge
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] kind;
        logic [6:0] arg1;
        logic [6:0] arg2;
    } cmd_t;
endpackage

// File: rtl/core/loco_front.sv
// Front end: accepts commands, classifies them and pushes a record to the
// queue. Depends on loco_pkg.
`timescale 1ns / 1ps
module loco_front #(
    parameter int SLOT_COUNT = loco_pkg::SLOT_COUNT_DEF
) (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_command,
    input  logic [6:0]       s_arg1,
    input  logic [6:0]       s_arg2,
    output logic             push,
    output loco_pkg::cmd_t   push_cmd,
    input  logic             full
);
    import loco_pkg::*;
    logic in_range;
    logic keep;
    cmd_t c;

    assign s_ready  = !full;
    assign in_range = {1'b0, s_arg1} < 8'(SLOT_COUNT);

    always_comb begin
        c.op   = OP_SIMPLE;
        c.kind = KIND_PWR_ON;
        c.arg1 = s_arg1;
        c.arg2 = s_arg2;
        keep   = 1'b1;
        case (s_command)
            OPC_PWR_ON:  c.kind = KIND_PWR_ON;
            OPC_PWR_OFF: c.kind = KIND_PWR_OFF;
            OPC_ESTOP:   c.kind = KIND_ESTOP;
            OPC_SW:      c.kind = KIND_ACC;
            OPC_LOCO:    c.op = OP_LOCO;
            OPC_MOVE: begin
                if (in_range && s_arg1 == s_arg2 && s_arg1 != 7'd0) begin
                    c.op = OP_MOVE;
                end else begin
                    c.op = OP_NACK;
                end
            end
            OPC_SPD: begin
                c.op = OP_SPD;
                keep = in_range;
            end
            OPC_DIRF: begin
                c.op = OP_DIRF;
                keep = in_range;
            end
            OPC_SND: begin
                c.op = OP_SND;
                keep = in_range;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push     = s_valid && s_ready && keep;
    assign push_cmd = c;
endmodule

// File: rtl/core/loco_queue.sv
// Small request queue between front and back end. Depends on loco_pkg.
`timescale 1ns / 1ps
module loco_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  loco_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output loco_pkg::cmd_t pop_cmd
);
    import loco_pkg::*;
    cmd_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign pop_cmd = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

// File: rtl/core/loco_back.sv
// Back end: slot table in a memory, slot search, table updates and result
// sequencing through an output register. Depends on loco_pkg.
`timescale 1ns / 1ps
module loco_back #(
    parameter int SLOT_COUNT = loco_pkg::SLOT_COUNT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty,
    output logic           pop,
    input  loco_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_kind,
    output logic [13:0]    m_loco_address,
    output logic [6:0]     m_speed,
    output logic           m_direction,
    output logic [3:0]     m_function_number,
    output logic           m_function_on,
    output logic [5:0]     m_accessory_address,
    output logic [1:0]     m_accessory_port,
    output logic           m_gate,
    output logic           m_switch_on,
    output logic [7:0]     m_tx_byte,
    output logic           m_last,
    output logic           busy
);
    import loco_pkg::*;
    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int DEPTH = SLOT_COUNT * 16;
    localparam int AW    = SW + 4;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLEAR  = 11'b00000000010,
        S_SRCH   = 11'b00000000100, // read stat of slot
        S_SRCH2  = 11'b00000001000, // read adr
        S_SRCH3  = 11'b00000010000, // read adr2, compare
        S_INIT   = 11'b00000100000,
        S_RDSLOT = 11'b00001000000, // read 13 bytes to send
        S_EMIT   = 11'b00010000000,
        S_FETCH  = 11'b00100000000, // read stat, adr, spd, dirf, adr2, snd
        S_WRITE  = 11'b01000000000,
        S_FUNC   = 11'b10000000000
    } st_t;

    st_t        st_reg;
    cmd_t       c_reg;
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_reg;
    logic [AW-1:0] ra, wa;
    logic          we;
    logic [7:0]    wd;
    logic [SW:0]   clr_reg;
    logic [SW:0]   s_reg, free_reg;
    logic [3:0]    b_reg;
    logic [3:0]    step_reg;
    logic [7:0]    stat_reg, adr_reg, spd_reg, dirf_reg, adr2_reg, snd_reg;
    logic [7:0]    chk_reg;
    logic [7:0]    tx_buf [14];
    logic [3:0]    tx_n_reg, tx_i_reg;
    logic [4:0]    lowf_reg;
    logic [3:0]    highf_reg;
    logic [3:0]    fi_reg;
    logic          thr_pend_reg;
    logic          ovalid_reg;
    logic          can_load;

    // output register
    logic [2:0]  k_reg;
    logic [13:0] a_reg;
    logic [6:0]  sp_reg;
    logic        d_reg, fo_reg, g_reg, so_reg, l_reg;
    logic [3:0]  fn_reg;
    logic [5:0]  aa_reg;
    logic [1:0]  ap_reg;
    logic [7:0]  tb_reg;

    assign m_valid = ovalid_reg;
    assign m_kind = k_reg; assign m_loco_address = a_reg; assign m_speed = sp_reg;
    assign m_direction = d_reg; assign m_function_number = fn_reg;
    assign m_function_on = fo_reg; assign m_accessory_address = aa_reg;
    assign m_accessory_port = ap_reg; assign m_gate = g_reg;
    assign m_switch_on = so_reg; assign m_tx_byte = tb_reg; assign m_last = l_reg;
    assign can_load = !ovalid_reg || m_ready;
    assign busy = st_reg == S_CLEAR;

    function automatic logic [AW-1:0] adx(input logic [SW:0] s, input logic [3:0] b);
        adx = {s[SW-1:0], b};
    endfunction

    logic [4:0] newlow;
    logic [4:0] fcur, fnew;
    logic [13:0] saddr;
    assign newlow = {dirf_reg[3:0], dirf_reg[4]};
    assign saddr  = {adr2_reg[6:0], 7'd0} + {7'd0, adr_reg[6:0]};
    assign fcur   = (c_reg.op == OP_SND) ? {1'b0, highf_reg} : lowf_reg;
    assign fnew   = (c_reg.op == OP_SND) ? {1'b0, snd_reg[3:0]} : newlow;

    // reset contents of a table byte
    function automatic logic [7:0] init_byte(input logic [SW:0] s, input logic [3:0] b);
        case (b)
            4'd0:    init_byte = SLOT_OPC;
            4'd1:    init_byte = SLOT_SIZE;
            4'd2:    init_byte = 8'(s + 1'b1);
            4'd3:    init_byte = MODE_128;
            default: init_byte = 8'h00;
        endcase
    endfunction

    always_comb begin
        ra = adx(s_reg, b_reg);
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_reg <= mem[ra];
    end

    logic lastf;
    always_comb begin
        lastf = 1'b1;
        for (int i = 0; i < 5; i++) begin
            if (i > int'(fi_reg) && fcur[i] != fnew[i]) lastf = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        we  <= 1'b0;
        pop <= 1'b0;
        if (can_load) ovalid_reg <= 1'b0;
        case (st_reg)
            S_CLEAR: begin
                we <= 1'b1;
                wa <= adx(clr_reg, b_reg);
                wd <= init_byte(clr_reg, b_reg);
                b_reg <= b_reg + 4'd1;
                if (b_reg == 4'd15) begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (SW+1)'(SLOT_COUNT - 1)) st_reg <= S_IDLE;
                end
            end
            S_IDLE: begin
                if (!empty && !pop && can_load) begin
                    c_reg <= cmd;
                    pop   <= 1'b1;
                    s_reg <= (SW+1)'(cmd.arg1);
                    step_reg <= '0;
                    b_reg <= 4'd3;
                    thr_pend_reg <= 1'b0;
                    case (cmd.op)
                        OP_SIMPLE: begin
                            ovalid_reg <= 1'b1;
                            {k_reg, a_reg, sp_reg, d_reg, fn_reg, fo_reg} <= '0;
                            {aa_reg, ap_reg, g_reg, so_reg, tb_reg} <= '0;
                            k_reg <= cmd.kind;
                            l_reg <= 1'b1;
                            if (cmd.kind == KIND_ACC) begin
                                aa_reg <= 6'(cmd.arg1[6:2]) + 6'd1;
                                ap_reg <= cmd.arg1[1:0];
                                g_reg  <= cmd.arg2[5];
                                so_reg <= cmd.arg2[4];
                            end
                        end
                        OP_NACK: begin
                            tx_buf[0] <= OPC_LACK; tx_buf[1] <= LACK_ECHO;
                            tx_buf[2] <= 8'h00; tx_buf[3] <= OPC_LACK ^ LACK_ECHO ^ 8'hFF;
                            tx_n_reg <= 4'd4; tx_i_reg <= '0;
                            st_reg <= S_EMIT;
                        end
                        OP_LOCO: begin
                            s_reg <= (SW+1)'(1);
                            free_reg <= (SW+1)'(SLOT_COUNT);
                            st_reg <= S_SRCH;
                        end
                        default: begin
                            b_reg <= 4'd3;
                            st_reg <= S_FETCH;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // read address issued for stat (b=3); its data is taken in the next cycle
                b_reg <= 4'd4; step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd1) begin
                    stat_reg <= rd_reg;
                    b_reg <= 4'd9; step_reg <= '0;
                    st_reg <= S_SRCH2;
                end
            end
            S_SRCH2: begin
                adr_reg <= rd_reg; // byte 4 read during previous cycle
                st_reg <= S_SRCH3;
            end
            S_SRCH3: begin
                if ((stat_reg & STAT_USE) == 8'h00) begin
                    free_reg <= s_reg;
                end else if (adr_reg == {1'b0, c_reg.arg2} && rd_reg == {1'b0, c_reg.arg1}) begin
                    b_reg <= 4'd0; step_reg <= '0; chk_reg <= '0;
                    st_reg <= S_RDSLOT;
                end
                if (!(((stat_reg & STAT_USE) != 8'h00) && adr_reg == {1'b0, c_reg.arg2}
                        && rd_reg == {1'b0, c_reg.arg1})) begin
                    if (s_reg == (SW+1)'(SLOT_COUNT - 1)) begin
                        if ((stat_reg & STAT_USE) == 8'h00) begin
                            s_reg <= s_reg; b_reg <= '0; st_reg <= S_INIT;
                        end else if (free_reg == (SW+1)'(SLOT_COUNT)) begin
                            tx_buf[0] <= OPC_LACK; tx_buf[1] <= LACK_ECHO;
                            tx_buf[2] <= 8'h00; tx_buf[3] <= OPC_LACK ^ LACK_ECHO ^ 8'hFF;
                            tx_n_reg <= 4'd4; tx_i_reg <= '0;
                            st_reg <= S_EMIT;
                        end else begin
                            s_reg <= free_reg; b_reg <= '0; st_reg <= S_INIT;
                        end
                    end else begin
                        s_reg <= s_reg + 1'b1; b_reg <= 4'd3; step_reg <= '0;
                        st_reg <= S_SRCH;
                    end
                end
            end
            S_INIT: begin
                we <= 1'b1;
                wa <= adx(s_reg, b_reg);
                case (b_reg)
                    4'd0: wd <= SLOT_OPC;
                    4'd1: wd <= SLOT_SIZE;
                    4'd2: wd <= 8'(s_reg);
                    4'd3: wd <= STAT_IDLE | MODE_128;
                    4'd4: wd <= {1'b0, c_reg.arg2};
                    4'd6: wd <= DIRF_F0;
                    4'd9: wd <= {1'b0, c_reg.arg1};
                    default: wd <= 8'h00;
                endcase
                b_reg <= b_reg + 4'd1;
                if (b_reg == 4'd12) begin
                    b_reg <= '0; step_reg <= '0; chk_reg <= '0;
                    st_reg <= S_RDSLOT;
                end
            end
            S_RDSLOT: begin
                // pipelined reads: byte b requested, its data registered in the next cycle
                if (step_reg != 4'd0) begin
                    tx_buf[step_reg - 4'd1] <= rd_reg;
                    chk_reg <= chk_reg ^ rd_reg;
                end
                step_reg <= step_reg + 4'd1;
                b_reg <= b_reg + 4'd1;
                if (step_reg == 4'd13) begin
                    tx_buf[13] <= chk_reg ^ rd_reg ^ 8'hFF;
                    tx_n_reg <= 4'd14; tx_i_reg <= '0;
                    st_reg <= S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    ovalid_reg <= 1'b1;
                    {k_reg, a_reg, sp_reg, d_reg, fn_reg, fo_reg} <= '0;
                    {aa_reg, ap_reg, g_reg, so_reg} <= '0;
                    k_reg <= KIND_TX;
                    tb_reg <= tx_buf[tx_i_reg];
                    l_reg <= tx_i_reg == tx_n_reg - 4'd1;
                    tx_i_reg <= tx_i_reg + 4'd1;
                    if (tx_i_reg == tx_n_reg - 4'd1) st_reg <= S_IDLE;
                end
            end
            S_FETCH: begin
                // read bytes 3,4,5,6,9,10 in turn
                step_reg <= step_reg + 4'd1;
                case (step_reg)
                    4'd0: b_reg <= 4'd4;
                    4'd1: begin stat_reg <= rd_reg; b_reg <= 4'd5; end
                    4'd2: begin adr_reg  <= rd_reg; b_reg <= 4'd6; end
                    4'd3: begin spd_reg  <= rd_reg; b_reg <= 4'd9; end
                    4'd4: begin dirf_reg <= rd_reg; b_reg <= 4'd10; end
                    4'd5: adr2_reg <= rd_reg;
                    default: begin
                        snd_reg <= rd_reg;
                        st_reg <= S_WRITE;
                    end
                endcase
            end
            S_WRITE: begin
                we <= 1'b1;
                fi_reg <= '0;
                thr_pend_reg <= c_reg.op != OP_SND;
                case (c_reg.op)
                    OP_MOVE: begin
                        wa <= adx(s_reg, 4'd3); wd <= stat_reg | STAT_USE;
                    end
                    OP_SPD: begin
                        wa <= adx(s_reg, 4'd5); wd <= {1'b0, c_reg.arg2};
                        spd_reg <= {1'b0, c_reg.arg2};
                    end
                    OP_DIRF: begin
                        wa <= adx(s_reg, 4'd6); wd <= {1'b0, c_reg.arg2};
                        dirf_reg <= {1'b0, c_reg.arg2};
                    end
                    default: begin
                        wa <= adx(s_reg, 4'd10); wd <= {1'b0, c_reg.arg2};
                        snd_reg <= {1'b0, c_reg.arg2};
                    end
                endcase
                st_reg <= S_FUNC;
            end
            S_FUNC: begin
                if (thr_pend_reg) begin
                    if (can_load) begin
                        ovalid_reg <= 1'b1;
                        {k_reg, a_reg, sp_reg, d_reg, fn_reg, fo_reg} <= '0;
                        {aa_reg, ap_reg, g_reg, so_reg, tb_reg} <= '0;
                        k_reg <= KIND_THR; a_reg <= saddr;
                        sp_reg <= spd_reg[6:0]; d_reg <= dirf_reg[5];
                        l_reg <= (c_reg.op == OP_SPD) || (newlow == lowf_reg);
                        thr_pend_reg <= 1'b0;
                        if (c_reg.op == OP_SPD) st_reg <= S_IDLE;
                    end
                end else if (fi_reg == ((c_reg.op == OP_SND) ? 4'd4 : 4'd5)) begin
                    if (c_reg.op == OP_SND) highf_reg <= snd_reg[3:0];
                    else lowf_reg <= newlow;
                    st_reg <= S_IDLE;
                end else if (fcur[fi_reg[2:0]] == fnew[fi_reg[2:0]]) begin
                    fi_reg <= fi_reg + 4'd1;
                end else if (can_load) begin
                    ovalid_reg <= 1'b1;
                    {k_reg, a_reg, sp_reg, d_reg, fn_reg, fo_reg} <= '0;
                    {aa_reg, ap_reg, g_reg, so_reg, tb_reg} <= '0;
                    k_reg <= KIND_FUNC; a_reg <= saddr;
                    fn_reg <= fi_reg + ((c_reg.op == OP_SND) ? 4'd5 : 4'd0);
                    fo_reg <= fnew[fi_reg[2:0]];
                    l_reg <= lastf;
                    fi_reg <= fi_reg + 4'd1;
                end
            end
            default: st_reg <= S_IDLE;
        endcase
        if (!aresetn) begin
            st_reg     <= S_CLEAR;
            clr_reg    <= '0;
            b_reg      <= '0;
            ovalid_reg <= 1'b0;
            we         <= 1'b0;
            pop        <= 1'b0;
            lowf_reg   <= '0;
            highf_reg  <= '0;
        end
    end
endmodule

// File: rtl/core/loco_slot_command_handler.sv
// A loco request searches the slots one by one, fills a free slot when none
// matches, then reads the slot and sends it as a reply byte by byte.
// The back end runs one command at a time; a loco request holds it through
// the table search over one read port, plus any reply stalls.
// Reset: synchronous active-low; afterwards a clearing pass writes every byte
// of the slot table; commands queue (up to 4) but are not run.
`timescale 1ns / 1ps
module loco_slot_command_handler #(
    parameter int SLOT_COUNT = loco_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_command,
    input  logic [6:0]  s_arg1,
    input  logic [6:0]  s_arg2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [13:0] m_loco_address,
    output logic [6:0]  m_speed,
    output logic        m_direction,
    output logic [3:0]  m_function_number,
    output logic        m_function_on,
    output logic [5:0]  m_accessory_address,
    output logic [1:0]  m_accessory_port,
    output logic        m_gate,
    output logic        m_switch_on,
    output logic [7:0]  m_tx_byte,
    output logic        m_last
);
    import loco_pkg::*;
    logic push, full, empty, pop, busy;
    cmd_t push_cmd, pop_cmd;

    // front end classifies each request and drops unknown opcodes and out-of-range slot updates
    loco_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .s_valid, .s_ready, .s_command, .s_arg1, .s_arg2,
        .push, .push_cmd, .full
    );

    loco_queue u_queue (
        .aclk, .aresetn, .push, .push_cmd, .full, .empty, .pop, .pop_cmd
    );

    // back end owns the slot table and the result register
    loco_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .aclk, .aresetn, .empty, .pop, .cmd(pop_cmd),
        .m_valid, .m_ready, .m_kind, .m_loco_address, .m_speed, .m_direction,
        .m_function_number, .m_function_on, .m_accessory_address,
        .m_accessory_port, .m_gate, .m_switch_on, .m_tx_byte, .m_last, .busy
    );

`ifndef NO_ASSERTIONS
    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !m_valid) else $error("result during table clear");
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= KIND_TX) else $error("bad result kind");
    a_fn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_FUNC) |-> m_function_number <= 4'd8)
        else $error("bad function number");
`endif
endmodule

// File: tb/loco_slot_command_handler_test.sv
// Testbench for loco_slot_command_handler: named tests feed command requests,
// a local slot-table predictor queues expected results, a checker compares them.
// Depends on loco_pkg and the RTL top only.
`timescale 1ns / 1ps
module loco_slot_command_handler_test;
    import loco_pkg::*;

    localparam int NSLOT = SLOT_COUNT_DEF;
    // Opcodes that the block ignores: a slot status request and one that means nothing.
    localparam logic [7:0] OPC_SLOT_STAT = 8'hB5;
    localparam logic [7:0] OPC_UNKNOWN   = 8'h00;
    // Long acknowledge reply: B4 E5 00 and its checksum.
    localparam logic [7:0] LACK_OPC = 8'hB4;
    localparam logic [7:0] LACK_ID  = 8'hE5;
    localparam logic [7:0] LACK_SUM = 8'hB4 ^ 8'hE5 ^ 8'h00 ^ 8'hFF;
    localparam logic [7:0] STAT_FIELD = 8'h30; // status bits; 00 means free
    localparam int STALL_LIMIT = 6000;          // cycles with no handshake
    localparam int HOLD_CYCLES = 500;           // long receiver hold-off

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] loco_address;
        logic [6:0]  speed;
        logic        direction;
        logic [3:0]  function_number;
        logic        function_on;
        logic [5:0]  accessory_address;
        logic [1:0]  accessory_port;
        logic        gate;
        logic        switch_on;
        logic [7:0]  tx_byte;
        logic        last;
    } loco_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_command;
    logic [6:0]  s_arg1;
    logic [6:0]  s_arg2;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [13:0] m_loco_address;
    logic [6:0]  m_speed;
    logic        m_direction;
    logic [3:0]  m_function_number;
    logic        m_function_on;
    logic [5:0]  m_accessory_address;
    logic [1:0]  m_accessory_port;
    logic        m_gate;
    logic        m_switch_on;
    logic [7:0]  m_tx_byte;
    logic        m_last;

    // Predictor state: slot table and the shared function memories.
    logic [7:0]   slot_mem [NSLOT][SLOT_BYTES];
    logic [4:0]   low_fn_mem;
    logic [3:0]   high_fn_mem;
    loco_result_t pending_results [$];

    int  mismatches;
    int  quiet_cycles;
    bit  idle_enable;   // random idling on both sides when set
    int  rx_hold;       // receiver hold-off, counted down by the receiver

    loco_slot_command_handler uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_arg1(s_arg1), .s_arg2(s_arg2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_loco_address(m_loco_address), .m_speed(m_speed),
        .m_direction(m_direction), .m_function_number(m_function_number),
        .m_function_on(m_function_on),
        .m_accessory_address(m_accessory_address),
        .m_accessory_port(m_accessory_port), .m_gate(m_gate),
        .m_switch_on(m_switch_on), .m_tx_byte(m_tx_byte), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic loco_result_t blank_result(logic [2:0] kind);
        loco_result_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic logic [13:0] slot_address(int s);
        return 14'(slot_mem[s][4]) + (14'(slot_mem[s][9]) << 7);
    endfunction

    task automatic queue_tx(logic [7:0] b);
        loco_result_t r;
        r = blank_result(KIND_TX);
        r.tx_byte = b;
        pending_results.push_back(r);
    endtask

    task automatic queue_long_ack();
        queue_tx(LACK_OPC);
        queue_tx(LACK_ID);
        queue_tx(8'h00);
        queue_tx(LACK_SUM);
    endtask

    task automatic queue_throttle(int s);
        loco_result_t r;
        r = blank_result(KIND_THR);
        r.loco_address = slot_address(s);
        r.speed = slot_mem[s][5][6:0];
        r.direction = slot_mem[s][6][5];
        pending_results.push_back(r);
    endtask

    // One function result per changed bit, ascending; base is 0 or 5.
    task automatic queue_function_changes(logic [4:0] now, logic [4:0] was,
                                          int nbits, int base, int s);
        loco_result_t r;
        for (int i = 0; i < nbits; i++) begin
            if (now[i] != was[i]) begin
                r = blank_result(KIND_FUNC);
                r.loco_address = slot_address(s);
                r.function_number = 4'(i + base);
                r.function_on = now[i];
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic queue_low_functions(int s);
        logic [4:0] f;
        f = {slot_mem[s][6][3:0], slot_mem[s][6][4]}; // F0 sits in dirf bit 4
        queue_function_changes(f, low_fn_mem, 5, 0, s);
        low_fn_mem = f;
    endtask

    // Search slots 1..N-1: first in-use match wins, else last free slot.
    task automatic predict_loco_request(logic [6:0] a1, logic [6:0] a2);
        int found;
        int free_slot;
        logic [7:0] chk;
        found = -1;
        free_slot = -1;
        for (int s = 1; s < NSLOT; s++) begin
            if ((slot_mem[s][3] & STAT_FIELD) == 8'h00) begin
                free_slot = s;
            end else if (slot_mem[s][4] == {1'b0, a2} && slot_mem[s][9] == {1'b0, a1}) begin
                found = s;
                break;
            end
        end
        if (found < 0 && free_slot < 0) begin
            queue_long_ack();
            return;
        end
        if (found < 0) begin
            found = free_slot;
            for (int i = 0; i < SLOT_BYTES; i++) slot_mem[found][i] = 8'h00;
            slot_mem[found][0] = SLOT_OPC;
            slot_mem[found][1] = SLOT_SIZE;
            slot_mem[found][2] = 8'(found);
            slot_mem[found][3] = STAT_IDLE | MODE_128;
            slot_mem[found][4] = {1'b0, a2};
            slot_mem[found][6] = DIRF_F0;
            slot_mem[found][9] = {1'b0, a1};
        end
        chk = 8'h00;
        for (int i = 0; i < SLOT_BYTES; i++) begin
            queue_tx(slot_mem[found][i]);
            chk ^= slot_mem[found][i];
        end
        queue_tx(chk ^ 8'hFF);
    endtask

    task automatic predict_command(logic [7:0] cmd, logic [6:0] a1, logic [6:0] a2);
        int prior_count;
        loco_result_t r;
        logic [3:0] hf;
        prior_count = pending_results.size();
        case (cmd)
            OPC_PWR_ON:  pending_results.push_back(blank_result(KIND_PWR_ON));
            OPC_PWR_OFF: pending_results.push_back(blank_result(KIND_PWR_OFF));
            OPC_ESTOP:   pending_results.push_back(blank_result(KIND_ESTOP));
            OPC_LOCO:    predict_loco_request(a1, a2);
            OPC_MOVE: begin
                if (a1 != a2 || a1 >= NSLOT || a1 < 1) begin
                    queue_long_ack();
                end else begin
                    slot_mem[a1][3] |= STAT_USE;
                    queue_throttle(a1);
                    queue_low_functions(a1);
                end
            end
            OPC_SPD: begin
                if (a1 < NSLOT) begin
                    slot_mem[a1][5] = {1'b0, a2};
                    queue_throttle(a1);
                end
            end
            OPC_DIRF: begin
                if (a1 < NSLOT) begin
                    slot_mem[a1][6] = {1'b0, a2};
                    queue_throttle(a1);
                    queue_low_functions(a1);
                end
            end
            OPC_SND: begin
                if (a1 < NSLOT) begin
                    slot_mem[a1][10] = {1'b0, a2};
                    hf = a2[3:0];
                    queue_function_changes({1'b0, hf}, {1'b0, high_fn_mem}, 4, 5, a1);
                    high_fn_mem = hf;
                end
            end
            OPC_SW: begin
                r = blank_result(KIND_ACC);
                r.accessory_address = 6'(a1[6:2]) + 6'd1;
                r.accessory_port = a1[1:0];
                r.gate = a2[5];
                r.switch_on = a2[4];
                pending_results.push_back(r);
            end
            default: ; // slot status and unknown opcodes: nothing
        endcase
        if (pending_results.size() > prior_count)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Request driver: one request, with an optional idle gap first.
    // ---------------------------------------------------------------
    task automatic send_request(logic [7:0] cmd, logic [6:0] a1, logic [6:0] a2);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(99) < 11) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_command <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_arg1 <= a1;
        s_arg2 <= a2;
        do @(posedge aclk); while (!s_ready);
        predict_command(cmd, a1, a2);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Sender stops and waits until every expected result has arrived.
    task automatic wait_drained();
        pause_sender();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready, plus a counted hold-off when asked.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= !(idle_enable && $urandom_range(99) < 11);
        end
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
                 got, want);
        mismatches++;
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        loco_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", m_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_kind != want.kind) report_mismatch("kind", m_kind, want.kind);
                if (m_loco_address != want.loco_address)
                    report_mismatch("loco_address", m_loco_address, want.loco_address);
                if (m_speed != want.speed) report_mismatch("speed", m_speed, want.speed);
                if (m_direction != want.direction)
                    report_mismatch("direction", m_direction, want.direction);
                if (m_function_number != want.function_number)
                    report_mismatch("function_number", m_function_number,
                                    want.function_number);
                if (m_function_on != want.function_on)
                    report_mismatch("function_on", m_function_on, want.function_on);
                if (m_accessory_address != want.accessory_address)
                    report_mismatch("accessory_address", m_accessory_address,
                                    want.accessory_address);
                if (m_accessory_port != want.accessory_port)
                    report_mismatch("accessory_port", m_accessory_port,
                                    want.accessory_port);
                if (m_gate != want.gate) report_mismatch("gate", m_gate, want.gate);
                if (m_switch_on != want.switch_on)
                    report_mismatch("switch_on", m_switch_on, want.switch_on);
                if (m_tx_byte != want.tx_byte)
                    report_mismatch("tx_byte", m_tx_byte, want.tx_byte);
                if (m_last != want.last) report_mismatch("last", m_last, want.last);
            end
        end
    end

    // Watchdog: too long with no handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("loco_slot_command_handler_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Power, emergency stop and switch requests, including field extremes.
    task automatic test_power_and_switch();
        send_request(OPC_PWR_ON, 7'd0, 7'd0);
        send_request(OPC_PWR_OFF, 7'h7F, 7'h7F);
        send_request(OPC_ESTOP, 7'd0, 7'd0);
        send_request(OPC_SW, 7'd0, 7'd0);
        send_request(OPC_SW, 7'h7F, 7'h7F);
        send_request(OPC_SW, 7'h55, 7'h20);
        send_request(OPC_SW, 7'h2A, 7'h10);
    endtask

    // Allocation, a repeat that matches, and ignored opcodes.
    task automatic test_loco_request();
        send_request(OPC_LOCO, 7'h7F, 7'h7F);
        send_request(OPC_LOCO, 7'd0, 7'd3);
        send_request(OPC_LOCO, 7'h7F, 7'h7F);
        send_request(OPC_SLOT_STAT, 7'd1, 7'd1);
        send_request(OPC_UNKNOWN, 7'd5, 7'd5);
    endtask

    // Move slots: bad arguments give the long ack; a good one a throttle and any function changes.
    task automatic test_move_slots();
        send_request(OPC_MOVE, 7'd1, 7'd2);
        send_request(OPC_MOVE, 7'd0, 7'd0);
        send_request(OPC_MOVE, 7'(NSLOT), 7'(NSLOT));
        send_request(OPC_MOVE, 7'(NSLOT - 1), 7'(NSLOT - 1));
    endtask

    // Speed, direction/function and sound, including slots out of range.
    task automatic test_slot_updates();
        send_request(OPC_SPD, 7'(NSLOT - 1), 7'h7F);
        send_request(OPC_DIRF, 7'(NSLOT - 1), 7'h3F);
        send_request(OPC_SND, 7'(NSLOT - 1), 7'h0F);
        send_request(OPC_SND, 7'd0, 7'h70);
        send_request(OPC_DIRF, 7'(NSLOT), 7'h1F);
        send_request(OPC_SPD, 7'h7F, 7'h7F);
        send_request(OPC_SND, 7'h7F, 7'h0F);
    endtask

    // Random requests, mostly well-formed slot traffic on a few addresses.
    task automatic send_random_request();
        int pick;
        logic [6:0] a1;
        logic [6:0] a2;
        pick = $urandom_range(99);
        a1 = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(NSLOT - 1));
        a2 = 7'($urandom);
        if (pick < 15)
            send_request(OPC_LOCO, 7'($urandom_range(2)), 7'($urandom_range(12)));
        else if (pick < 22)
            send_request(OPC_MOVE, a1, ($urandom_range(3) == 0) ? a2 : a1);
        else if (pick < 42) send_request(OPC_SPD, a1, a2);
        else if (pick < 60) send_request(OPC_DIRF, a1, a2);
        else if (pick < 72) send_request(OPC_SND, a1, a2);
        else if (pick < 82) send_request(OPC_SW, 7'($urandom), a2);
        else if (pick < 90)
            send_request(OPC_PWR_OFF + 8'($urandom_range(3)), a1, a2);
        else send_request(8'($urandom), 7'($urandom), a2);
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_random_request();
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        rx_hold <= HOLD_CYCLES;
        repeat (20) send_random_request();
    endtask

    // Distinct new addresses until no slot is left: the long ack follows.
    task automatic test_table_full();
        for (int i = 0; i < NSLOT + 1; i++) send_request(OPC_LOCO, 7'h7E, 7'(i));
        send_request(OPC_LOCO, 7'h7F, 7'h7F);
        send_request(OPC_MOVE, 7'd3, 7'd3);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = 8'h00;
        s_arg1 = 7'd0;
        s_arg2 = 7'd0;
        m_ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        rx_hold = 0;
        idle_enable = 1'b1;
        for (int s = 0; s < NSLOT; s++) begin
            for (int i = 0; i < SLOT_BYTES; i++) slot_mem[s][i] = 8'h00;
            slot_mem[s][0] = SLOT_OPC;
            slot_mem[s][1] = SLOT_SIZE;
            slot_mem[s][2] = 8'(s + 1);
            slot_mem[s][3] = MODE_128;
        end
        low_fn_mem = '0;
        high_fn_mem = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_and_switch();
        test_loco_request();
        test_move_slots();
        test_slot_updates();
        test_random_traffic(150);
        idle_enable = 1'b0;          // a stretch with no idling at all
        test_random_traffic(60);
        idle_enable = 1'b1;
        test_backpressure();
        wait_drained();
        test_random_traffic(110);
        test_table_full();
        test_random_traffic(30);

        pause_sender();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("loco_slot_command_handler_test: PASS");
        end else begin
            $display("loco_slot_command_handler_test: FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/loco_pkg.sv
rtl/core/loco_front.sv
rtl/core/loco_queue.sv
rtl/core/loco_back.sv
rtl/core/loco_slot_command_handler.sv
tb/loco_slot_command_handler_test.sv
